/* hw/rtl/rfd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Rusanov flux divergence core.
// No dependencies; imported by the core module.
package rfd_pkg;

  localparam int WordBits   = 32;
  localparam int FracBits   = 24;
  localparam int NumVars    = 5;
  localparam int NumPrims   = 4;
  localparam int ExtBits    = 56;
  localparam int AccBits    = 36;
  localparam int TotBits    = 42;
  localparam int MulBits    = 34;
  localparam int CfgIdxBits = 3;
  localparam int DivSteps   = 32;
  localparam int SqrtSteps  = 28;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [ExtBits-1:0]  ext_t;
  typedef logic signed [AccBits-1:0]  acc_t;
  typedef logic signed [TotBits-1:0]  tot_t;
  typedef logic signed [MulBits-1:0]  mul_t;

  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CFG_GRAVITY   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_CELL_SCALE = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_DRY_THRESH = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_LEFT_VEL  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_LEFT_FLD  = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_RIGHT_VEL = 3'd5;
  localparam logic [CfgIdxBits-1:0] CFG_RIGHT_FLD = 3'd6;

  localparam logic [30:0] GravityReset   = 31'd164584489;
  localparam logic [15:0] CellScaleReset = 16'd100;
  localparam logic [30:0] DryThreshReset = 31'd1;

  // Primitive slots kept per cell.
  localparam logic [1:0] PRIM_U = 2'd0;
  localparam logic [1:0] PRIM_V = 2'd1;
  localparam logic [1:0] PRIM_A = 2'd2;
  localparam logic [1:0] PRIM_B = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DISPATCH,
    ST_SPEED,
    ST_SQRT,
    ST_FLUX,
    ST_DIFF,
    ST_SCALE,
    ST_OUT
  } state_e;

  function automatic word_t sat_word(input ext_t x);
    if (&x[ExtBits-1:WordBits-1] || ~|x[ExtBits-1:WordBits-1]) begin
      return word_t'(x[WordBits-1:0]);
    end else if (x[ExtBits-1]) begin
      return WordMin;
    end else begin
      return WordMax;
    end
  endfunction

  function automatic logic is_wet(input word_t h, input logic [30:0] thr);
    logic signed [WordBits:0] hx;
    logic [WordBits:0] mag;
    hx  = {h[WordBits-1], h};
    mag = hx[WordBits] ? -hx : hx;
    return (h != '0) && (mag >= {2'b00, thr});
  endfunction

  // Signs and saturates an unsigned quotient magnitude.
  function automatic word_t div_final(input logic [WordBits-1:0] q, input logic neg);
    if (neg) begin
      if (q > {1'b1, {(WordBits-1){1'b0}}}) begin
        return WordMin;
      end else begin
        return word_t'(-q);
      end
    end else if (q[WordBits-1]) begin
      return WordMax;
    end else begin
      return word_t'(q);
    end
  endfunction

endpackage

/* hw/rtl/rusanov_flux_divergence_first_order_core.sv */
`timescale 1ns / 1ps
// First-order Rusanov rate of change for a shallow-water MHD cell stream.
// Depends on rfd_pkg for types, constants and arithmetic helpers.

// The core takes one cell per transfer and works on it alone; in_ready_o is high only
// when it is idle. Every cell first goes through four 32-step restoring divisions for
// its primitives, each skipped for zero depth or an oversized quotient. A left ghost
// or an ignored cell ends there. The first interior cell adds one face speed (two
// 28-step square roots); later cells add the face speed, the two neighbour fluxes, the
// dissipation terms and the scaling on one shared 34x34 multiplier. The result sits in
// an output register, so the next cell is taken while it waits.
module rusanov_flux_divergence_first_order_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rfd_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [rfd_pkg::WordBits-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [rfd_pkg::WordBits-1:0]   cell_h_i,
  input  logic signed [rfd_pkg::WordBits-1:0]   cell_hu_i,
  input  logic signed [rfd_pkg::WordBits-1:0]   cell_hv_i,
  input  logic signed [rfd_pkg::WordBits-1:0]   cell_ha_i,
  input  logic signed [rfd_pkg::WordBits-1:0]   cell_hb_i,
  input  logic                                  is_left_ghost_i,
  input  logic                                  is_right_ghost_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rfd_pkg::WordBits-1:0]   rate_h_o,
  output logic signed [rfd_pkg::WordBits-1:0]   rate_hu_o,
  output logic signed [rfd_pkg::WordBits-1:0]   rate_hv_o,
  output logic signed [rfd_pkg::WordBits-1:0]   rate_ha_o,
  output logic signed [rfd_pkg::WordBits-1:0]   rate_hb_o,
  output logic [30:0]                           max_speed_o,
  output logic                                  last_cell_o
);
  import rfd_pkg::*;

  // Configuration.
  logic [30:0] grav_q, thr_q;
  logic [15:0] ncell_q;
  word_t       ldv_q, ldf_q, rdv_q, rdf_q;

  // Control.
  state_e      state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [2:0]  idx_q, idx_d;
  logic        side_q, side_d;
  logic [1:0]  fill_q, fill_d;
  logic        lg_q, lg_d, rg_q, rg_d;
  logic        out_valid_q, out_valid_d;
  logic [30:0] rmax_q, rmax_d;
  word_t       lfs_q, lfs_d;

  // Cell window: raw cells and their primitives.
  word_t cur_q [NumVars];
  word_t cur_d [NumVars];
  word_t lc_q  [NumVars];
  word_t lc_d  [NumVars];
  word_t mc_q  [NumVars];
  word_t mc_d  [NumVars];
  word_t cp_q  [NumPrims];
  word_t cp_d  [NumPrims];
  word_t lp_q  [NumPrims];
  word_t lp_d  [NumPrims];
  word_t mp_q  [NumPrims];
  word_t mp_d  [NumPrims];

  // Working registers.
  word_t br_q, br_d, spd_q, spd_d, tmp_q, tmp_d;
  acc_t  acc_q, acc_d;
  tot_t  tot_q [NumVars];
  tot_t  tot_d [NumVars];

  // Divider.
  logic [WordBits:0]   dv_ad_q, dv_ad_d, dv_rem_q, dv_rem_d;
  logic [WordBits-1:0] dv_low_q, dv_low_d, dv_quo_q, dv_quo_d;
  logic                dv_neg_q, dv_neg_d;
  logic [4:0]          dv_cnt_q, dv_cnt_d;

  // Square root.
  logic [55:0] sq_rad_q, sq_rad_d;
  logic [30:0] sq_rem_q, sq_rem_d;
  logic [27:0] sq_root_q, sq_root_d;
  logic [4:0]  sq_cnt_q, sq_cnt_d;

  // Result register.
  word_t       out_rate_q [NumVars];
  word_t       out_rate_d [NumVars];
  logic [30:0] out_max_q, out_max_d;
  logic        out_last_q, out_last_d;

  // Shared multiplier.
  mul_t                mul_a, mul_b;
  logic signed [67:0]  mul_p;
  word_t               mul_qv;
  assign mul_p  = mul_a * mul_b;
  assign mul_qv = sat_word(ext_t'(mul_p >>> FracBits));

  // Datapath selections.
  word_t               sd_h, sd_u, sd_a, sd_uu, sd_aa, sd_spd, num_sel;
  logic                sd_wet, wet_k, wet_m, dv_ge, sq_ge, load_out;
  word_t               fk [NumVars];
  word_t               fp [NumPrims];
  word_t               pe, d1, d2, res, bnew;
  word_t               fres;
  logic signed [33:0]  cs_x, d_x, p_x, ad_x, m_x;
  logic signed [WordBits:0] nx, dx;
  logic [WordBits:0]   na, dn, dv_r2;
  logic [WordBits-1:0] qn;
  logic [30:0]         sq_r4, sq_trial;
  logic signed [67:0]  rnd, half;
  ext_t                fl;

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= GravityReset;
      ncell_q <= CellScaleReset;
      thr_q   <= DryThreshReset;
      ldv_q   <= '0;
      ldf_q   <= '0;
      rdv_q   <= '0;
      rdf_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAVITY:    grav_q  <= cfg_data_i[30:0];
        CFG_CELL_SCALE: ncell_q <= cfg_data_i[15:0];
        CFG_DRY_THRESH: thr_q   <= cfg_data_i[30:0];
        CFG_LEFT_VEL:   ldv_q   <= word_t'(cfg_data_i);
        CFG_LEFT_FLD:   ldf_q   <= word_t'(cfg_data_i);
        CFG_RIGHT_VEL:  rdv_q   <= word_t'(cfg_data_i);
        CFG_RIGHT_FLD:  rdf_q   <= word_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      idx_q       <= '0;
      side_q      <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      rmax_q      <= '0;
      lfs_q       <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      side_q      <= side_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      rmax_q      <= rmax_d;
      lfs_q       <= lfs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lg_q       <= lg_d;
    rg_q       <= rg_d;
    cur_q      <= cur_d;
    lc_q       <= lc_d;
    mc_q       <= mc_d;
    cp_q       <= cp_d;
    lp_q       <= lp_d;
    mp_q       <= mp_d;
    br_q       <= br_d;
    spd_q      <= spd_d;
    tmp_q      <= tmp_d;
    acc_q      <= acc_d;
    tot_q      <= tot_d;
    dv_ad_q    <= dv_ad_d;
    dv_rem_q   <= dv_rem_d;
    dv_low_q   <= dv_low_d;
    dv_quo_q   <= dv_quo_d;
    dv_neg_q   <= dv_neg_d;
    dv_cnt_q   <= dv_cnt_d;
    sq_rad_q   <= sq_rad_d;
    sq_rem_q   <= sq_rem_d;
    sq_root_q  <= sq_root_d;
    sq_cnt_q   <= sq_cnt_d;
    out_rate_q <= out_rate_d;
    out_max_q  <= out_max_d;
    out_last_q <= out_last_d;
  end

  // Operand selection for the speed, flux and divider steps.
  always_comb begin
    // Side of a face: side 0 is the left cell, side 1 the incoming cell.
    sd_h   = side_q ? cur_q[0] : ((fill_q == 2'd1) ? lc_q[0] : mc_q[0]);
    sd_u   = side_q ? cp_q[PRIM_U] : ((fill_q == 2'd1) ? lp_q[PRIM_U] : mp_q[PRIM_U]);
    sd_a   = side_q ? cp_q[PRIM_A] : ((fill_q == 2'd1) ? lp_q[PRIM_A] : mp_q[PRIM_A]);
    sd_wet = is_wet(sd_h, thr_q);
    sd_uu  = sd_wet ? sd_u : (side_q ? rdv_q : ldv_q);
    sd_aa  = sd_wet ? sd_a : (side_q ? rdf_q : ldf_q);
    cs_x   = $signed({6'b0, sq_root_q});
    d_x    = mul_t'(sd_uu) - cs_x;
    p_x    = mul_t'(sd_uu) + cs_x;
    ad_x   = d_x[33] ? -d_x : d_x;
    m_x    = (ad_x > p_x) ? ad_x : p_x;
    sd_spd = sat_word(ext_t'(m_x));

    // Flux neighbour: pass 0 takes the incoming cell, pass 1 the left cell.
    if (side_q) begin
      fk = lc_q;
      fp = lp_q;
    end else begin
      fk = cur_q;
      fp = cp_q;
    end
    wet_k = is_wet(fk[0], thr_q);
    wet_m = is_wet(mc_q[0], thr_q);

    d1 = sat_word(ext_t'(mc_q[idx_q]) - ext_t'(lc_q[idx_q]));
    d2 = sat_word(ext_t'(cur_q[idx_q]) - ext_t'(mc_q[idx_q]));

    num_sel = cur_q[3'(idx_q[1:0]) + 3'd1];
    nx      = {num_sel[WordBits-1], num_sel};
    na      = nx[WordBits] ? -nx : nx;
    dx      = {cur_q[0][WordBits-1], cur_q[0]};
    dn      = dx[WordBits] ? -dx : dx;
    dv_r2   = {dv_rem_q[WordBits-1:0], dv_low_q[WordBits-1]};
    dv_ge   = (dv_r2 >= dv_ad_q);
    qn      = {dv_quo_q[WordBits-2:0], dv_ge};

    sq_r4    = {sq_rem_q[28:0], sq_rad_q[55:54]};
    sq_trial = {1'b0, sq_root_q, 2'b01};
    sq_ge    = (sq_r4 >= sq_trial);

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SPEED: begin
        if (step_q == 4'd0) begin
          mul_a = mul_t'(sd_aa);
          mul_b = mul_t'(sd_aa);
        end else begin
          mul_a = {3'b000, grav_q};
          mul_b = mul_t'(sd_h);
        end
      end
      ST_FLUX: begin
        case (step_q)
          4'd0: begin mul_a = mul_t'(fk[1]); mul_b = mul_t'(fp[PRIM_U]); end
          4'd1: begin mul_a = mul_t'(fk[3]); mul_b = mul_t'(fp[PRIM_A]); end
          4'd2: begin mul_a = {3'b000, grav_q}; mul_b = mul_t'(fk[0]); end
          4'd3: begin mul_a = mul_t'(tmp_q); mul_b = mul_t'(fk[0]); end
          4'd4: begin mul_a = mul_t'(fk[1]); mul_b = mul_t'(fp[PRIM_V]); end
          4'd5: begin mul_a = mul_t'(fk[3]); mul_b = mul_t'(fp[PRIM_B]); end
          4'd6: begin mul_a = mul_t'(fk[1]); mul_b = mul_t'(fp[PRIM_B]); end
          4'd7: begin mul_a = mul_t'(fk[2]); mul_b = mul_t'(fp[PRIM_A]); end
          4'd8: begin mul_a = mul_t'(fk[3]); mul_b = mul_t'(mp_q[PRIM_V]); end
          4'd9: begin mul_a = mul_t'(fk[3]); mul_b = mul_t'(mp_q[PRIM_U]); end
          default: ;
        endcase
      end
      ST_DIFF: begin
        mul_a = step_q[0] ? mul_t'(br_q) : mul_t'(lfs_q);
        mul_b = step_q[0] ? mul_t'(d2) : mul_t'(d1);
      end
      ST_SCALE: begin
        // A clamped total still saturates the same way once scaled.
        if (&tot_q[idx_q][TotBits-1:MulBits-1] || ~|tot_q[idx_q][TotBits-1:MulBits-1]) begin
          mul_a = tot_q[idx_q][MulBits-1:0];
        end else if (tot_q[idx_q][TotBits-1]) begin
          mul_a = {1'b1, {(MulBits-1){1'b0}}};
        end else begin
          mul_a = {1'b0, {(MulBits-1){1'b1}}};
        end
        mul_b = {18'b0, ncell_q};
      end
      default: ;
    endcase

    // Gate terms of a dry neighbour or a dry middle cell.
    if (step_q == 4'd8 || step_q == 4'd9) begin
      pe = wet_m ? mul_qv : '0;
    end else begin
      pe = wet_k ? mul_qv : '0;
    end

    fl   = ext_t'(mul_p >>> FracBits);
    rnd  = mul_p + $signed({67'b0, mul_p[67]});
    half = rnd >>> 1;
    res  = sat_word(ext_t'(-half));

    bnew = (lfs_q > br_q) ? lfs_q : br_q;
    bnew = (bnew > word_t'({1'b0, rmax_q})) ? bnew : word_t'({1'b0, rmax_q});

    load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  end

  // Sequencer: next state and register updates.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    idx_d       = idx_q;
    side_d      = side_q;
    fill_d      = fill_q;
    lg_d        = lg_q;
    rg_d        = rg_q;
    rmax_d      = rmax_q;
    lfs_d       = lfs_q;
    cur_d       = cur_q;
    lc_d        = lc_q;
    mc_d        = mc_q;
    cp_d        = cp_q;
    lp_d        = lp_q;
    mp_d        = mp_q;
    br_d        = br_q;
    spd_d       = spd_q;
    tmp_d       = tmp_q;
    acc_d       = acc_q;
    tot_d       = tot_q;
    dv_ad_d     = dv_ad_q;
    dv_rem_d    = dv_rem_q;
    dv_low_d    = dv_low_q;
    dv_quo_d    = dv_quo_q;
    dv_neg_d    = dv_neg_q;
    dv_cnt_d    = dv_cnt_q;
    sq_rad_d    = sq_rad_q;
    sq_rem_d    = sq_rem_q;
    sq_root_d   = sq_root_q;
    sq_cnt_d    = sq_cnt_q;
    out_rate_d  = out_rate_q;
    out_max_d   = out_max_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    fres        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cur_d[0] = cell_h_i;
          cur_d[1] = cell_hu_i;
          cur_d[2] = cell_hv_i;
          cur_d[3] = cell_ha_i;
          cur_d[4] = cell_hb_i;
          lg_d     = is_left_ghost_i;
          rg_d     = is_right_ghost_i;
          idx_d    = '0;
          state_d  = ST_DIV_START;
        end
      end

      ST_DIV_START: begin
        dv_neg_d = num_sel[WordBits-1] ^ cur_q[0][WordBits-1];
        if (cur_q[0] == '0 || {8'b0, na} >= {dn, 8'b0}) begin
          // Zero depth gives zero; an oversized quotient saturates at once.
          if (cur_q[0] == '0) begin
            cp_d[idx_q[1:0]] = '0;
          end else begin
            cp_d[idx_q[1:0]] = dv_neg_d ? WordMin : WordMax;
          end
          if (idx_q[1:0] == 2'd3) begin
            state_d = ST_DISPATCH;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end else begin
          dv_ad_d  = dn;
          dv_rem_d = na >> 8;
          dv_low_d = {na[7:0], 24'b0};
          dv_quo_d = '0;
          dv_cnt_d = '0;
          state_d  = ST_DIV_RUN;
        end
      end

      ST_DIV_RUN: begin
        dv_rem_d = dv_ge ? dv_r2 - dv_ad_q : dv_r2;
        dv_low_d = {dv_low_q[WordBits-2:0], 1'b0};
        dv_quo_d = qn;
        dv_cnt_d = dv_cnt_q + 5'd1;
        if (dv_cnt_q == 5'(DivSteps - 1)) begin
          cp_d[idx_q[1:0]] = div_final(qn, dv_neg_q);
          if (idx_q[1:0] == 2'd3) begin
            state_d = ST_DISPATCH;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = ST_DIV_START;
          end
        end
      end

      ST_DISPATCH: begin
        if (lg_q) begin
          lc_d    = cur_q;
          lp_d    = cp_q;
          fill_d  = 2'd1;
          rmax_d  = '0;
          lfs_d   = '0;
          state_d = ST_IDLE;
        end else if (fill_q == 2'd0) begin
          state_d = ST_IDLE;
        end else begin
          side_d  = 1'b0;
          step_d  = '0;
          state_d = ST_SPEED;
        end
      end

      ST_SPEED: begin
        case (step_q)
          4'd0: begin
            acc_d  = acc_t'(mul_qv);
            step_d = 4'd1;
          end
          4'd1: begin
            acc_d  = acc_q + acc_t'(mul_qv);
            step_d = 4'd2;
          end
          4'd2: begin
            tmp_d = sat_word(ext_t'(acc_q));
            if (tmp_d[WordBits-1] || tmp_d == '0) begin
              sq_rad_d = '0;
            end else begin
              sq_rad_d = {1'b0, tmp_d[30:0], 24'b0};
            end
            sq_rem_d  = '0;
            sq_root_d = '0;
            sq_cnt_d  = '0;
            step_d    = 4'd3;
            state_d   = ST_SQRT;
          end
          default: begin
            if (!side_q) begin
              spd_d  = sd_spd;
              side_d = 1'b1;
              step_d = '0;
            end else begin
              spd_d = (sd_spd > spd_q) ? sd_spd : spd_q;
              if (fill_q == 2'd1) begin
                lfs_d   = spd_d;
                mc_d    = cur_q;
                mp_d    = cp_q;
                fill_d  = rg_q ? 2'd0 : 2'd2;
                state_d = ST_IDLE;
              end else begin
                br_d    = spd_d;
                tot_d   = '{default: '0};
                side_d  = 1'b0;
                step_d  = '0;
                state_d = ST_FLUX;
              end
            end
          end
        endcase
      end

      ST_SQRT: begin
        sq_rem_d  = sq_ge ? sq_r4 - sq_trial : sq_r4;
        sq_root_d = {sq_root_q[26:0], sq_ge};
        sq_rad_d  = {sq_rad_q[53:0], 2'b00};
        sq_cnt_d  = sq_cnt_q + 5'd1;
        if (sq_cnt_q == 5'(SqrtSteps - 1)) begin
          state_d = ST_SPEED;
        end
      end

      ST_FLUX: begin
        step_d = step_q + 4'd1;
        case (step_q)
          4'd0: acc_d = acc_t'(pe);
          4'd1: acc_d = acc_q - acc_t'(pe);
          4'd2: tmp_d = mul_qv;
          4'd3: acc_d = acc_q + (wet_k ? acc_t'(mul_qv >>> 1) : acc_t'(0));
          4'd4, 4'd6: begin
            fres = sat_word(ext_t'(acc_q));
            if (side_q) begin
              tot_d[step_q[2:1] - 2'd1] = tot_q[step_q[2:1] - 2'd1] - tot_t'(fres);
            end else begin
              tot_d[step_q[2:1] - 2'd1] = tot_q[step_q[2:1] - 2'd1] + tot_t'(fres);
            end
            acc_d = acc_t'(pe);
          end
          4'd5, 4'd7: acc_d = acc_q - acc_t'(pe);
          4'd8: acc_d = acc_q + acc_t'(pe);
          4'd9: begin
            fres = sat_word(ext_t'(acc_q));
            tot_d[4] = side_q ? tot_q[4] - tot_t'(fres) : tot_q[4] + tot_t'(fres);
            acc_d = acc_t'(pe);
          end
          default: begin
            fres = wet_k ? fk[1] : '0;
            tot_d[0] = side_q ? tot_q[0] - tot_t'(fres) : tot_q[0] + tot_t'(fres);
            tot_d[3] = side_q ? tot_q[3] - tot_t'(acc_q) : tot_q[3] + tot_t'(acc_q);
            step_d = '0;
            if (!side_q) begin
              side_d = 1'b1;
            end else begin
              idx_d   = '0;
              state_d = ST_DIFF;
            end
          end
        endcase
      end

      ST_DIFF: begin
        tot_d[idx_q] = step_q[0] ? tot_q[idx_q] - tot_t'(fl) : tot_q[idx_q] + tot_t'(fl);
        step_d = {3'b000, ~step_q[0]};
        if (step_q[0]) begin
          if (idx_q == 3'(NumVars - 1)) begin
            idx_d   = '0;
            state_d = ST_SCALE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end

      ST_SCALE: begin
        tot_d[idx_q] = tot_t'(res);
        if (idx_q == 3'(NumVars - 1)) begin
          state_d = ST_OUT;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end

      ST_OUT: begin
        if (load_out) begin
          for (int k = 0; k < NumVars; k++) begin
            out_rate_d[k] = word_t'(tot_q[k][WordBits-1:0]);
          end
          out_max_d   = bnew[30:0];
          out_last_d  = rg_q;
          out_valid_d = 1'b1;
          rmax_d      = bnew[30:0];
          lfs_d       = br_q;
          lc_d        = mc_q;
          lp_d        = mp_q;
          mc_d        = cur_q;
          mp_d        = cp_q;
          fill_d      = rg_q ? 2'd0 : 2'd2;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign rate_h_o    = out_rate_q[0];
  assign rate_hu_o   = out_rate_q[1];
  assign rate_hv_o   = out_rate_q[2];
  assign rate_ha_o   = out_rate_q[3];
  assign rate_hb_o   = out_rate_q[4];
  assign max_speed_o = out_max_q;
  assign last_cell_o = out_last_q;

  // The flux and dissipation steps run only with a full window.
  a_full_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUX || state_q == ST_DIFF || state_q == ST_SCALE) |-> fill_q == 2'd2)
    else $error("flux sequence entered without a full window");

  // The partial remainder of the divider stays below the divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_RUN) |-> dv_rem_q < dv_ad_q)
    else $error("divider remainder out of range");

  // A waiting result is never overwritten by the next one.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=>
      ($stable(out_rate_q[0]) && $stable(out_max_q) && $stable(out_last_q)))
    else $error("pending result overwritten");

  // The square root count never runs past its last digit.
  a_sqrt_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> sq_cnt_q < 5'(SqrtSteps))
    else $error("square root step count overrun");

endmodule
